// File: rtl/core/tebt_pkg.sv
// shared widths, register index codes and chain command type for the top-k budget tracker
package tebt_pkg;

  localparam int ItemW   = 32;
  localparam int CountW  = 32;
  localparam int SumW    = 48;
  localparam int PowerW  = 47;
  localparam int SkipW   = 7;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_BASE_POWER  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BONUS_POWER = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SKIP_COUNT  = 2'd2;

  // clear empties the row, shift inserts the value in sorted place,
  // grow extends the occupied part by one cell
  typedef struct packed {
    logic clear;
    logic shift;
    logic grow;
  } chain_cmd_t;

endpackage

// File: rtl/core/tebt_ifs.sv
// valid/ready channel interfaces for items, results and register writes
interface tebt_item_if import tebt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ItemW-1:0]  item_value;
  logic              start_of_set;
  logic              last_in_set;

  modport source (output valid, item_value, start_of_set, last_in_set, input ready);
  modport sink   (input valid, item_value, start_of_set, last_in_set, output ready);
endinterface

interface tebt_result_if import tebt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] cleared_count;
  logic              stopped;
  logic              set_done;

  modport source (output valid, cleared_count, stopped, set_done, input ready);
  modport sink   (input valid, cleared_count, stopped, set_done, output ready);
endinterface

interface tebt_cfg_if import tebt_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] reg_index;
  logic [PowerW-1:0]  write_data;

  modport source (output valid, reg_index, write_data, input ready);
  modport sink   (input valid, reg_index, write_data, output ready);
endinterface

// File: rtl/core/tebt_cell.sv
// one cell of the sorted top-k row: holds a value and its valid bit
module tebt_cell import tebt_pkg::*; #(
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  chain_cmd_t    cmd,
  input  logic [VW-1:0] value,
  input  logic [VW-1:0] prev_val,
  input  logic          prev_take,
  input  logic          prev_valid,
  input  logic          next_valid,
  output logic [VW-1:0] val,
  output logic          valid,
  output logic          take,
  output logic [VW-1:0] tail
);

  // row is sorted largest first, so take is monotonic along the row
  assign take = !valid || (value > val);
  assign tail = (valid && !next_valid) ? val : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.clear) begin
      valid <= 1'b0;
    end else if (cmd.grow) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift && take) begin
      val <= prev_take ? prev_val : value;
    end
  end

endmodule

// File: rtl/core/tebt_chain.sv
// row of sorted cells holding the largest values of the set, with the smallest one read out
module tebt_chain import tebt_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int VW    = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  chain_cmd_t    cmd,
  input  logic [VW-1:0] value,
  output logic [VW-1:0] min_val
);

  logic [VW-1:0] vals   [DEPTH];
  logic [VW-1:0] tails  [DEPTH];
  logic          valids [DEPTH];
  logic          takes  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VW-1:0] p_val;
    logic          p_take;
    logic          p_valid;
    logic          n_valid;

    if (i == 0) begin : g_head
      assign p_val   = '0;
      assign p_take  = 1'b0;
      assign p_valid = 1'b1;
    end else begin : g_body
      assign p_val   = vals[i-1];
      assign p_take  = takes[i-1];
      assign p_valid = valids[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign n_valid = 1'b0;
    end else begin : g_mid
      assign n_valid = valids[i+1];
    end

    tebt_cell #(.VW(VW)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .value      (value),
      .prev_val   (p_val),
      .prev_take  (p_take),
      .prev_valid (p_valid),
      .next_valid (n_valid),
      .val        (vals[i]),
      .valid      (valids[i]),
      .take       (takes[i]),
      .tail       (tails[i])
    );
  end

  // only the last occupied cell drives a nonzero tail
  always_comb begin
    min_val = '0;
    for (int i = 0; i < DEPTH; i++) begin
      min_val = min_val | tails[i];
    end
  end

endmodule

// File: rtl/core/topk_excess_budget_tracker_core.sv
// top level of the streaming top-k excess budget tracker
//
//   channel  dir  handshake            payload
//   item     in   valid/ready          item_value, start_of_set, last_in_set
//   result   out  valid/ready          cleared_count, stopped, set_done
//   cfg      in   valid/ready (ready=1) reg_index, write_data
//
// each item passes accept with min readout, then chain/sum update, then budget check
// a new item is accepted while the previous result still waits in the output register
// the budget check holds when that register is still full and not taken
// rst clears control and config registers, sums, counters and every cell valid bit at once; no sweep
// the sorted cell row shifts one place per insertion
module topk_excess_budget_tracker_core import tebt_pkg::*; #(
  parameter int MAX_SKIP   = 64,
  parameter int VALUE_BITS = 32
) (
  input logic         clk,
  input logic         rst,
  tebt_item_if.sink   item,
  tebt_result_if.source result,
  tebt_cfg_if.sink    cfg
);

  localparam int VW = (VALUE_BITS < ItemW) ? VALUE_BITS : ItemW;
  localparam int FW = $clog2(MAX_SKIP + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_UPD   = 2'd1;
  localparam logic [1:0] S_JUDGE = 2'd2;

  logic [1:0]        state;
  logic [PowerW-1:0] base_power;
  logic [PowerW-1:0] bonus_power;
  logic [SkipW-1:0]  skip_count;

  logic [VW-1:0]     value;
  logic              last_flag;
  logic [VW-1:0]     min_val;
  logic [FW-1:0]     top_fill;
  logic [SumW-1:0]   top_sum;
  logic [SumW-1:0]   total_sum;
  logic [CountW-1:0] item_index;
  logic [CountW-1:0] count_reg;
  logic              halted;
  logic              judge;
  logic [SumW-1:0]   budget;

  logic              out_valid;
  logic [CountW-1:0] out_count;
  logic              out_stopped;
  logic              out_done;

  logic              acc;
  chain_cmd_t        cmd;
  logic [VW-1:0]     chain_min;

  logic [CountW-1:0] idx_inc;
  logic [CountW-1:0] count_inc;
  logic [CountW-1:0] skip_ext;
  logic [CountW-1:0] k_lim;
  logic              in_head;
  logic              do_grow;
  logic              do_swap;
  logic [SumW:0]     total_add;
  logic [SumW-1:0]   total_next;
  logic [SumW:0]     grow_add;
  logic [SumW-1:0]   top_less;
  logic [SumW:0]     swap_add;
  logic [SumW-1:0]   excess;
  logic              pass;
  logic              go;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_power  <= '0;
      bonus_power <= '0;
      skip_count  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        CFG_BASE_POWER:  base_power  <= cfg.write_data;
        CFG_BONUS_POWER: bonus_power <= cfg.write_data;
        CFG_SKIP_COUNT:  skip_count  <= cfg.write_data[SkipW-1:0];
        default: ;
      endcase
    end
  end

  assign item.ready = (state == S_IDLE);
  assign acc        = item.valid && item.ready;

  tebt_chain #(.DEPTH(MAX_SKIP), .VW(VW)) u_chain (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .value   (value),
    .min_val (chain_min)
  );

  always_comb begin
    idx_inc   = (item_index != '1) ? item_index + 1'b1 : item_index;
    count_inc = (count_reg != '1) ? count_reg + 1'b1 : count_reg;
    skip_ext  = CountW'(skip_count);
    k_lim     = (skip_ext > CountW'(MAX_SKIP)) ? CountW'(MAX_SKIP) : skip_ext;
    in_head   = (idx_inc <= k_lim);
    do_grow   = !halted && in_head && (top_fill < FW'(MAX_SKIP));
    do_swap   = !halted && !in_head && (top_fill != '0) && (value > min_val);

    cmd.clear = acc && item.start_of_set;
    cmd.shift = (state == S_UPD) && (do_grow || do_swap);
    cmd.grow  = (state == S_UPD) && do_grow;

    total_add  = {1'b0, total_sum} + (SumW + 1)'(value);
    total_next = total_add[SumW] ? '1 : total_add[SumW-1:0];
    grow_add   = {1'b0, top_sum} + (SumW + 1)'(value);
    top_less   = (top_sum >= SumW'(min_val)) ? top_sum - SumW'(min_val) : '0;
    swap_add   = {1'b0, top_less} + (SumW + 1)'(value);

    excess = (total_sum > top_sum) ? total_sum - top_sum : '0;
    pass   = (excess <= budget);
    go     = !out_valid || result.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      top_fill   <= '0;
      top_sum    <= '0;
      total_sum  <= '0;
      item_index <= '0;
      count_reg  <= '0;
      halted     <= 1'b0;
      judge      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (state == S_JUDGE && go) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (item.start_of_set) begin
              top_fill   <= '0;
              top_sum    <= '0;
              total_sum  <= '0;
              item_index <= '0;
              count_reg  <= '0;
              halted     <= 1'b0;
            end
            state <= S_UPD;
          end
        end
        S_UPD: begin
          judge <= !halted && !in_head;
          if (!halted) begin
            item_index <= idx_inc;
            total_sum  <= total_next;
            if (do_grow) begin
              top_fill <= top_fill + 1'b1;
              top_sum  <= grow_add[SumW] ? '1 : grow_add[SumW-1:0];
            end else if (do_swap) begin
              top_sum  <= swap_add[SumW] ? '1 : swap_add[SumW-1:0];
            end
            if (in_head) begin
              count_reg <= count_inc;
            end
          end
          state <= S_JUDGE;
        end
        S_JUDGE: begin
          if (go) begin
            if (judge) begin
              if (pass) begin
                count_reg <= count_inc;
              end else begin
                halted <= 1'b1;
              end
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      value     <= VW'(item.item_value);
      last_flag <= item.last_in_set;
      min_val   <= chain_min;
    end
    if (state == S_UPD) begin
      budget <= SumW'(base_power) + SumW'(bonus_power);
    end
    if (state == S_JUDGE && go) begin
      out_count   <= (judge && pass) ? count_inc : count_reg;
      out_stopped <= halted || (judge && !pass);
      out_done    <= last_flag;
    end
  end

  assign result.valid         = out_valid;
  assign result.cleared_count = out_count;
  assign result.stopped       = out_stopped;
  assign result.set_done      = out_done;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    top_fill <= FW'(MAX_SKIP))
    else $error("top fill beyond row depth");

  a_count_le_index: assert property (@(posedge clk) disable iff (rst)
    count_reg <= item_index)
    else $error("count ahead of item index");

  a_halt_freezes: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD && halted) |=> $stable(top_sum) && $stable(count_reg)
      && $stable(total_sum))
    else $error("state changed after halt");

  a_halt_sticks: assert property (@(posedge clk) disable iff (rst)
    (halted && !(acc && item.start_of_set)) |=> halted)
    else $error("halt dropped without a new set");

  a_judge_emits: assert property (@(posedge clk) disable iff (rst)
    (state == S_JUDGE && go) |=> (result.valid && state == S_IDLE))
    else $error("budget check finished without a result");
`endif

endmodule

// File: sim/tb_topk_excess_budget_tracker_core.sv
// self-checking testbench for the streaming top-k excess budget tracker core
`timescale 1ns / 100ps

module tb_topk_excess_budget_tracker_core;
  import tebt_pkg::*;

  localparam int MAX_SKIP    = 64;
  localparam int ItemTarget  = 550;
  localparam int HoldCycles  = 80;

  typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_t;
  typedef enum int {SPAN_TINY, SPAN_SMALL, SPAN_WIDE, SPAN_FULL, SPAN_EDGE} value_span_t;

  typedef struct packed {
    logic [ItemW-1:0] value;
    logic             start;
    logic             last;
  } item_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic              stopped;
    logic              done;
  } verdict_t;

  logic clk = 1'b0;
  logic rst;

  tebt_item_if   item_ch ();
  tebt_result_if result_ch ();
  tebt_cfg_if    cfg_ch ();

  topk_excess_budget_tracker_core #(
    .MAX_SKIP  (MAX_SKIP),
    .VALUE_BITS(ItemW)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies and per-set tracking state
  logic [PowerW-1:0] base_cfg;
  logic [PowerW-1:0] bonus_cfg;
  logic [SkipW-1:0]  skip_cfg;
  logic [ItemW-1:0]  top_vals [MAX_SKIP];
  int unsigned       top_fill_m;
  logic [SumW-1:0]   top_total;
  logic [SumW-1:0]   set_total;
  logic [CountW-1:0] pos_in_set;
  logic [CountW-1:0] count_m;
  logic              halted_m;

  item_t    pending_items [$];
  verdict_t expected_verdicts [$];
  item_t    on_offer;

  int pushed_total   = 0;
  int accepted_total = 0;
  int checked_total  = 0;
  int mismatch_cnt   = 0;
  int sets_opened    = 0;
  int stopped_seen   = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  int hold_left      = 0;
  bit hold_arm       = 1'b0;
  bit hold_taken     = 1'b0;
  idle_mode_t sender_idle   = IDLE_NONE;
  idle_mode_t receiver_idle = IDLE_NONE;

  function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] a,
                                               input logic [SumW-1:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumW] ? {SumW{1'b1}} : s[SumW-1:0];
  endfunction

  function automatic void clear_tracker();
    foreach (top_vals[i]) top_vals[i] = '0;
    top_fill_m = 0;
    top_total  = '0;
    set_total  = '0;
    pos_in_set = '0;
    count_m    = '0;
    halted_m   = 1'b0;
  endfunction

  function automatic verdict_t track_item(input item_t it);
    int unsigned     k;
    int              i;
    int              low_idx;
    logic [SumW-1:0] allowed;
    logic [SumW-1:0] excess;
    k = (skip_cfg > MAX_SKIP) ? MAX_SKIP : skip_cfg;
    if (it.start) clear_tracker();
    if (!halted_m) begin
      if (pos_in_set != {CountW{1'b1}}) pos_in_set++;
      set_total = sat_add(set_total, SumW'(it.value));
      if (pos_in_set <= k) begin
        if (top_fill_m < MAX_SKIP) begin
          top_vals[top_fill_m] = it.value;
          top_fill_m++;
          top_total = sat_add(top_total, SumW'(it.value));
        end
        if (count_m != {CountW{1'b1}}) count_m++;
      end else begin
        allowed = SumW'(base_cfg) + SumW'(bonus_cfg);
        if (top_fill_m > 0) begin
          // the new value pushes out the smallest stored one if it beats it
          low_idx = 0;
          for (i = 1; i < top_fill_m; i++)
            if (top_vals[i] < top_vals[low_idx]) low_idx = i;
          if (it.value > top_vals[low_idx]) begin
            top_total = (top_total >= SumW'(top_vals[low_idx])) ?
                        top_total - SumW'(top_vals[low_idx]) : '0;
            top_total = sat_add(top_total, SumW'(it.value));
            top_vals[low_idx] = it.value;
          end
        end
        excess = (set_total > top_total) ? set_total - top_total : '0;
        if (excess <= allowed) begin
          if (count_m != {CountW{1'b1}}) count_m++;
        end else begin
          halted_m = 1'b1;
        end
      end
    end
    return '{count: count_m, stopped: halted_m, done: it.last};
  endfunction

  function automatic int draw_wait(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 13);
      default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
    endcase
  endfunction

  function automatic logic [ItemW-1:0] gen_value(input value_span_t span);
    if ($urandom_range(0, 19) == 0) return $urandom;
    case (span)
      SPAN_TINY:  return $urandom_range(0, 15);
      SPAN_SMALL: return $urandom_range(0, 1000);
      SPAN_WIDE:  return $urandom_range(0, 65535);
      SPAN_FULL:  return $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return 32'd1;
          default: return 32'h8000_0000;
        endcase
      end
    endcase
  endfunction

  // allowed excess sized to the values of the phase so sets run a while before stopping
  function automatic logic [SumW-1:0] budget_for(input value_span_t span);
    case (span)
      SPAN_TINY:  return $urandom_range(0, 80);
      SPAN_SMALL: return $urandom_range(0, 30000);
      SPAN_WIDE:  return $urandom_range(0, 3000000);
      default:    return SumW'({5'($urandom_range(0, 31)), 32'($urandom)});
    endcase
  endfunction

  // item channel driver
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        expected_verdicts.push_back(track_item(on_offer));
        accepted_total++;
        gap_left = draw_wait(sender_idle);
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left == 0 && pending_items.size() != 0) begin
          on_offer = pending_items.pop_front();
          item_ch.valid        <= 1'b1;
          item_ch.item_value   <= on_offer.value;
          item_ch.start_of_set <= on_offer.start;
          item_ch.last_in_set  <= on_offer.last;
        end else begin
          if (gap_left > 0) gap_left--;
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result channel monitor and checker
  always @(posedge clk) begin : result_monitor
    verdict_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (result_ch.stopped) stopped_seen++;
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual count %0d stopped %0b done %0b",
                   $time, result_ch.cleared_count, result_ch.stopped, result_ch.set_done);
          mismatch_cnt++;
        end else begin
          want = expected_verdicts.pop_front();
          checked_total++;
          if (result_ch.cleared_count !== want.count) begin
            $display("%0t: cleared_count mismatch: expected %0d actual %0d",
                     $time, want.count, result_ch.cleared_count);
            mismatch_cnt++;
          end
          if (result_ch.stopped !== want.stopped) begin
            $display("%0t: stopped mismatch: expected %0b actual %0b",
                     $time, want.stopped, result_ch.stopped);
            mismatch_cnt++;
          end
          if (result_ch.set_done !== want.done) begin
            $display("%0t: set_done mismatch: expected %0b actual %0b",
                     $time, want.done, result_ch.set_done);
            mismatch_cnt++;
          end
        end
        stall_left = draw_wait(receiver_idle);
      end
      // long hold-off so the core fills up and stalls its input
      if (hold_arm && !hold_taken) begin
        hold_left  = HoldCycles;
        hold_taken = 1'b1;
      end
      if (!hold_arm) hold_taken = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_item(input logic [ItemW-1:0] value, input logic start,
                           input logic last);
    pending_items.push_back('{value: value, start: start, last: last});
    pushed_total++;
    if (start) sets_opened++;
  endtask

  // well-formed sets open with start and close with last; noisy ones scatter both flags
  task automatic push_set(input int len, input value_span_t span, input bit noisy);
    int n;
    for (n = 0; n < len; n++) begin
      if (noisy)
        push_item(gen_value(span), $urandom_range(0, 5) == 0, $urandom_range(0, 3) == 0);
      else
        push_item(gen_value(span), n == 0, n == len - 1);
    end
  endtask

  task automatic wait_drained();
    while (!(accepted_total == pushed_total && checked_total == accepted_total))
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_config(input logic [PowerW-1:0] base, input logic [PowerW-1:0] bonus,
                              input logic [SkipW-1:0] skip);
    logic [CfgIdxW-1:0] idx [3];
    logic [PowerW-1:0]  data [3];
    int n;
    idx  = '{CFG_BASE_POWER, CFG_BONUS_POWER, CFG_SKIP_COUNT};
    data = '{base, bonus, PowerW'(skip)};
    for (n = 0; n < 3; n++) begin
      cfg_ch.valid      <= 1'b1;
      cfg_ch.reg_index  <= idx[n];
      cfg_ch.write_data <= data[n];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      case (idx[n])
        CFG_BASE_POWER:  base_cfg  = data[n];
        CFG_BONUS_POWER: bonus_cfg = data[n];
        default:         skip_cfg  = data[n][SkipW-1:0];
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    value_span_t       span;
    logic [SumW-1:0]   allowed;
    logic [PowerW-1:0] base;
    logic [PowerW-1:0] bonus;
    logic [SkipW-1:0]  skip;
    int                k;
    int                phase_idx;
    int                phase_start;
    int                phase_goal;
    rst                  = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.item_value   = '0;
    item_ch.start_of_set = 1'b0;
    item_ch.last_in_set  = 1'b0;
    result_ch.ready      = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.reg_index     = CFG_BASE_POWER;
    cfg_ch.write_data    = '0;
    base_cfg  = '0;
    bonus_cfg = '0;
    skip_cfg  = '0;
    clear_tracker();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset registers: no exempt values and no budget, so the first nonzero value stops
    push_item(32'd0, 1'b1, 1'b0);
    push_item(32'd0, 1'b0, 1'b0);
    push_item(32'd5, 1'b0, 1'b0);
    push_item(32'd7, 1'b0, 1'b1);
    wait_drained();

    // largest budget, skip above the store depth, fewer items than k, continuation after last
    write_config({PowerW{1'b1}}, {PowerW{1'b1}}, {SkipW{1'b1}});
    push_item(32'hFFFF_FFFF, 1'b1, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b0, 1'b0);
    push_item(32'd0, 1'b0, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b0, 1'b1);
    push_item(32'd123, 1'b0, 1'b0);
    wait_drained();

    // minimum replaced by a larger value, then the budget runs out
    write_config(47'd10, 47'd0, 7'd2);
    push_item(32'd100, 1'b1, 1'b0);
    push_item(32'd50, 1'b0, 1'b0);
    push_item(32'd5, 1'b0, 1'b0);
    push_item(32'd200, 1'b0, 1'b0);
    push_item(32'd1, 1'b0, 1'b1);
    wait_drained();

    // k lowered in the middle of a set
    write_config(47'd0, 47'd1000, 7'd5);
    push_item(32'd10, 1'b1, 1'b0);
    push_item(32'd20, 1'b0, 1'b0);
    wait_drained();
    write_config(47'd0, 47'd1000, 7'd1);
    push_item(32'd30, 1'b0, 1'b0);
    push_item(32'd40, 1'b0, 1'b1);
    wait_drained();

    phase_idx = 0;
    while (pushed_total < ItemTarget) begin
      span = value_span_t'($urandom_range(0, 4));
      case ($urandom_range(0, 7))
        0:       skip = 7'd0;
        1:       skip = 7'd1;
        2:       skip = $urandom_range(2, 8);
        3:       skip = $urandom_range(0, 16);
        4:       skip = $urandom_range(0, 64);
        5:       skip = 7'd64;
        6:       skip = $urandom_range(65, 127);
        default: skip = 7'd127;
      endcase
      case ($urandom_range(0, 9))
        0: begin
          base  = '0;
          bonus = '0;
        end
        1: begin
          base  = {PowerW{1'b1}};
          bonus = {PowerW{1'b1}};
        end
        2: begin
          base  = PowerW'({$urandom, $urandom});
          bonus = PowerW'({$urandom, $urandom});
        end
        default: begin
          allowed = budget_for(span);
          base    = PowerW'({$urandom, $urandom} % (64'(allowed) + 64'd1));
          bonus   = PowerW'(allowed - SumW'(base));
        end
      endcase
      write_config(base, bonus, skip);
      k = (skip > MAX_SKIP) ? MAX_SKIP : skip;

      if (phase_idx == 1) begin
        sender_idle   <= IDLE_NONE;
        receiver_idle <= IDLE_NONE;
        hold_arm      <= 1'b1;
        push_set(50, span, 1'b0);
      end else begin
        sender_idle   <= idle_mode_t'($urandom_range(0, 2));
        receiver_idle <= idle_mode_t'($urandom_range(0, 2));
        phase_start = pushed_total;
        phase_goal  = $urandom_range(20, 60);
        while (pushed_total - phase_start < phase_goal && pushed_total < ItemTarget) begin
          if ($urandom_range(0, 4) == 0)
            push_set($urandom_range(1, 12), span, 1'b1);
          else
            push_set($urandom_range(1, 24) + (($urandom_range(0, 3) == 0) ? k : 0),
                     span, 1'b0);
        end
      end
      // sender holds off here until every outstanding result is in
      wait_drained();
      if (phase_idx == 1) hold_arm <= 1'b0;
      phase_idx++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (expected_verdicts.size() != 0) begin
      $display("%0t: %0d results expected but never delivered", $time,
               expected_verdicts.size());
      mismatch_cnt += expected_verdicts.size();
    end
    $display("run covered %0d items over %0d random phases plus directed cases, %0d sets opened",
             accepted_total, phase_idx, sets_opened);
    $display("%0d results checked, %0d with the stop flag, %0d mismatches",
             checked_total, stopped_seen, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/tebt_pkg.sv
rtl/core/tebt_ifs.sv
rtl/core/tebt_cell.sv
rtl/core/tebt_chain.sv
rtl/core/topk_excess_budget_tracker_core.sv
sim/tb_topk_excess_budget_tracker_core.sv
